// ===== sv/u16u8_pkg.sv =====
// Shared types and constants for the UTF-16 to UTF-8 encoder.
package u16u8_pkg;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        end_of_string;
	} unit_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} utf8_item_t;

	localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
	localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
	localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
	localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
	localparam logic [15:0] ASCII_MAX     = 16'h007F;
	localparam logic [15:0] TWO_BYTE_MAX  = 16'h07FF;
	localparam logic [20:0] SUPP_BASE     = 21'h10000;
	localparam logic [7:0]  LEAD4         = 8'hF0;
	localparam logic [7:0]  LEAD3         = 8'hE0;
	localparam logic [7:0]  LEAD2         = 8'hC0;
	localparam logic [7:0]  CONT          = 8'h80;
	localparam logic [7:0]  INVALID_BYTE  = 8'h3F;

endpackage

// ===== sv/utf16_to_utf8_encoder.sv =====
// UTF-16 to UTF-8 encoder: input register, encode logic, byte output buffer.
// An accepted unit is registered in stage 1; its 0 to 4 bytes load into the
// four-byte output buffer once that is free, then leave one byte per cycle while
// utf8_ready is high. The next unit waits in stage 1 until the buffer drains;
// units that make no bytes (held surrogate, stopped string) leave it empty.
// Reset (arst_n low, asynchronous): both stages empty, no surrogate held, string live.
module utf16_to_utf8_encoder
	import u16u8_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       code_valid,
	output logic       code_ready,
	input  unit_item_t code_item,
	output logic       utf8_valid,
	input  logic       utf8_ready,
	output utf8_item_t utf8_item
);

	// Stage 1: registered input transaction.
	logic       valid_s1;
	unit_item_t item_s1;

	// Decoder state carried between units.
	logic       high_pending_q;
	logic [9:0] high_bits_q;
	logic       stopped_q;

	// Output buffer: bytes left to send, next byte in slot 0.
	logic [3:0][7:0] bytes_q;
	logic [2:0]      cnt_q;

	// Encode results for the unit in stage 1.
	logic [3:0][7:0] enc_bytes;
	logic [2:0]      enc_cnt;
	logic            nx_pending;
	logic [9:0]      nx_bits;
	logic            nx_stopped;

	logic out_fire;
	logic buf_free;
	logic advance;

	assign out_fire   = utf8_valid && utf8_ready;
	// Buffer is free if empty or its last byte leaves this cycle.
	assign buf_free   = (cnt_q == 3'd0) || (out_fire && cnt_q == 3'd1);
	assign advance    = valid_s1 && buf_free;
	// Stage 1 takes a new transaction whenever it is empty or empties this cycle.
	assign code_ready = !valid_s1 || advance;

	assign utf8_valid            = (cnt_q != 3'd0);
	assign utf8_item.out_byte    = bytes_q[0];
	assign utf8_item.last_of_run = (cnt_q == 3'd1);

	// Encoder: one pass of range compares and bit slicing.
	always_comb begin
		logic [15:0] cu;
		logic [20:0] cp;
		cu         = item_s1.code_unit;
		cp         = SUPP_BASE + {1'b0, high_bits_q, cu[9:0]};
		enc_bytes  = '0;
		enc_cnt    = 3'd0;
		nx_pending = high_pending_q;
		nx_bits    = high_bits_q;
		nx_stopped = stopped_q;
		if (!stopped_q) begin
			if (high_pending_q) begin
				if (cu inside {[LOW_SURR_MIN:LOW_SURR_MAX]}) begin
					enc_bytes[0] = LEAD4 | {5'd0, cp[20:18]};
					enc_bytes[1] = CONT | {2'd0, cp[17:12]};
					enc_bytes[2] = CONT | {2'd0, cp[11:6]};
					enc_bytes[3] = CONT | {2'd0, cp[5:0]};
					enc_cnt      = 3'd4;
				end else begin
					enc_bytes[0] = INVALID_BYTE;
					enc_cnt      = 3'd1;
				end
				nx_pending = 1'b0;
				nx_bits    = '0;
			end else if (cu == 16'd0) begin
				nx_stopped = 1'b1;
			end else if (cu <= ASCII_MAX) begin
				enc_bytes[0] = cu[7:0];
				enc_cnt      = 3'd1;
			end else if (cu <= TWO_BYTE_MAX) begin
				enc_bytes[0] = LEAD2 | {3'd0, cu[10:6]};
				enc_bytes[1] = CONT | {2'd0, cu[5:0]};
				enc_cnt      = 3'd2;
			end else if (cu inside {[HIGH_SURR_MIN:HIGH_SURR_MAX]}) begin
				nx_pending = 1'b1;
				nx_bits    = cu[9:0];
			end else if (cu inside {[LOW_SURR_MIN:LOW_SURR_MAX]}) begin
				enc_bytes[0] = INVALID_BYTE;
				enc_cnt      = 3'd1;
			end else begin
				enc_bytes[0] = LEAD3 | {4'd0, cu[15:12]};
				enc_bytes[1] = CONT | {2'd0, cu[11:6]};
				enc_bytes[2] = CONT | {2'd0, cu[5:0]};
				enc_cnt      = 3'd3;
			end
		end
		// End-of-string mark clears state after this unit.
		if (item_s1.end_of_string) begin
			nx_pending = 1'b0;
			nx_bits    = '0;
			nx_stopped = 1'b0;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			cnt_q          <= 3'd0;
			high_pending_q <= 1'b0;
			high_bits_q    <= '0;
			stopped_q      <= 1'b0;
		end else begin
			if (code_ready) begin
				valid_s1 <= code_valid;
			end
			if (advance) begin
				cnt_q          <= enc_cnt;
				high_pending_q <= nx_pending;
				high_bits_q    <= nx_bits;
				stopped_q      <= nx_stopped;
			end else if (out_fire) begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (code_ready && code_valid) begin
			item_s1 <= code_item;
		end
		if (advance) begin
			bytes_q <= enc_bytes;
		end else if (out_fire) begin
			bytes_q <= {8'd0, bytes_q[3:1]};
		end
	end

	// A stopped string makes no bytes for a unit without an end mark.
	a_stopped_silent: assert property (@(posedge clk) disable iff (!arst_n)
		advance && stopped_q && !item_s1.end_of_string |=> cnt_q == 3'd0)
		else $error("stopped string produced output");

	// A high surrogate on a live string is held and makes no bytes.
	a_high_held: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !stopped_q && !high_pending_q && !item_s1.end_of_string &&
		item_s1.code_unit >= HIGH_SURR_MIN && item_s1.code_unit <= HIGH_SURR_MAX
		|=> high_pending_q && cnt_q == 3'd0)
		else $error("high surrogate not held");

	// Any unit after a held surrogate clears it.
	a_pending_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		advance && high_pending_q |=> !high_pending_q)
		else $error("held surrogate not consumed");

	// A stalled output keeps its remaining byte count.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		utf8_valid && !utf8_ready |=> $stable(cnt_q))
		else $error("byte count changed under stall");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the UTF-16 to UTF-8 encoder.
`timescale 1ns / 1ps

module tb_top
	import u16u8_pkg::*;
();

	localparam int          RESET_CYCLES  = 5;
	localparam int          RANDOM_UNITS  = 300;
	localparam int          DRAIN_CYCLES  = 16;
	localparam int unsigned CYCLE_LIMIT   = 300000;
	localparam int          DIRECTED_ROWS = 26;

	// Row kinds of the directed table: expected bytes typed into the row,
	// or left to the encoder model.
	localparam logic TYPED     = 1'b1;
	localparam logic PREDICTED = 1'b0;

	// Expected bytes sit MSB first in the row: bytes[31:24] leaves first.
	typedef struct packed {
		logic [15:0] cu;
		logic        eos;
		logic        typed;
		logic [2:0]  n;
		logic [31:0] bytes;
	} directed_row_t;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_RANDOM,
		READY_MOSTLY,
		READY_SPARSE
	} stall_style_t;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       code_valid = 1'b0;
	logic       code_ready;
	unit_item_t code_item  = '0;
	logic       utf8_valid;
	logic       utf8_ready = 1'b0;
	utf8_item_t utf8_item;

	// Side information carried along with the unit on offer; only the
	// scoreboard reads it, at the edge where the transaction is taken.
	logic        row_typed = PREDICTED;
	logic [2:0]  row_n     = '0;
	logic [31:0] row_bytes = '0;

	// Encoder model state, advanced once per accepted unit.
	logic       held_high      = 1'b0;
	logic [9:0] held_bits      = '0;
	logic       stream_stopped = 1'b0;

	utf8_item_t  utf8_expected_q [$];
	int          live_units  = 0;
	int          err_count   = 0;
	int          burst_left  = 1;
	int unsigned cycle_count = 0;

	// Directed sweep: field extremes, every encoding length, and the
	// surrogate and terminator corner cases in sequence.
	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{16'h0041, 1'b0, TYPED,     3'd1, 32'h41000000},
		'{16'h007F, 1'b0, TYPED,     3'd1, 32'h7F000000},
		'{16'h0080, 1'b0, TYPED,     3'd2, 32'hC2800000},
		'{16'h07FF, 1'b0, TYPED,     3'd2, 32'hDFBF0000},
		'{16'h0800, 1'b0, TYPED,     3'd3, 32'hE0A08000},
		'{16'hFFFF, 1'b0, TYPED,     3'd3, 32'hEFBFBF00},
		'{16'hD7FF, 1'b0, PREDICTED, 3'd0, 32'h00000000},
		'{16'hE000, 1'b0, PREDICTED, 3'd0, 32'h00000000},
		// lowest and highest supplementary code points
		'{16'hD800, 1'b0, TYPED,     3'd0, 32'h00000000},
		'{16'hDC00, 1'b0, TYPED,     3'd4, 32'hF0908080},
		'{16'hDBFF, 1'b0, TYPED,     3'd0, 32'h00000000},
		'{16'hDFFF, 1'b0, TYPED,     3'd4, 32'hF48FBFBF},
		// lone low surrogate
		'{16'hDC00, 1'b0, TYPED,     3'd1, 32'h3F000000},
		// high then plain unit: '?' and the unit is dropped
		'{16'hD800, 1'b0, TYPED,     3'd0, 32'h00000000},
		'{16'h0041, 1'b0, TYPED,     3'd1, 32'h3F000000},
		// high then high: second one replaced by '?'
		'{16'hDABC, 1'b0, PREDICTED, 3'd0, 32'h00000000},
		'{16'hD912, 1'b0, TYPED,     3'd1, 32'h3F000000},
		// zero after high gives '?' and the string keeps going
		'{16'hDB00, 1'b0, TYPED,     3'd0, 32'h00000000},
		'{16'h0000, 1'b0, TYPED,     3'd1, 32'h3F000000},
		'{16'h0042, 1'b0, TYPED,     3'd1, 32'h42000000},
		// high with end of string: discarded, next low is lone
		'{16'hD800, 1'b1, TYPED,     3'd0, 32'h00000000},
		'{16'hDFFF, 1'b0, TYPED,     3'd1, 32'h3F000000},
		// terminator, ignored unit, clear on a stopped unit, restart
		'{16'h0000, 1'b0, TYPED,     3'd0, 32'h00000000},
		'{16'h6C34, 1'b0, PREDICTED, 3'd0, 32'h00000000},
		'{16'h0000, 1'b1, TYPED,     3'd0, 32'h00000000},
		'{16'h00E9, 1'b0, TYPED,     3'd2, 32'hC3A90000}
	};

	utf16_to_utf8_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.code_valid(code_valid),
		.code_ready(code_ready),
		.code_item (code_item),
		.utf8_valid(utf8_valid),
		.utf8_ready(utf8_ready),
		.utf8_item (utf8_item)
	);

	always #2 clk = ~clk;

	// Encoder model: consumes one unit, returns the byte count and the
	// bytes MSB first, and updates the surrogate and terminator state.
	function automatic int encode_unit(input unit_item_t u, output logic [31:0] bytes);
		logic [15:0] cu;
		logic [20:0] cp;
		int          n;
		cu    = u.code_unit;
		n     = 0;
		bytes = '0;
		if (!stream_stopped) begin
			if (held_high) begin
				if (cu >= LOW_SURR_MIN && cu <= LOW_SURR_MAX) begin
					cp    = SUPP_BASE + {1'b0, held_bits, cu[9:0]};
					bytes = {LEAD4 | {5'b0, cp[20:18]}, CONT | {2'b0, cp[17:12]},
						CONT | {2'b0, cp[11:6]}, CONT | {2'b0, cp[5:0]}};
					n     = 4;
				end else begin
					bytes = {INVALID_BYTE, 24'h0};
					n     = 1;
				end
				held_high = 1'b0;
				held_bits = '0;
			end else if (cu == '0) begin
				stream_stopped = 1'b1;
			end else if (cu <= ASCII_MAX) begin
				bytes = {cu[7:0], 24'h0};
				n     = 1;
			end else if (cu <= TWO_BYTE_MAX) begin
				bytes = {LEAD2 | {3'b0, cu[10:6]}, CONT | {2'b0, cu[5:0]}, 16'h0};
				n     = 2;
			end else if (cu >= HIGH_SURR_MIN && cu <= HIGH_SURR_MAX) begin
				held_high = 1'b1;
				held_bits = cu[9:0];
			end else if (cu >= LOW_SURR_MIN && cu <= LOW_SURR_MAX) begin
				bytes = {INVALID_BYTE, 24'h0};
				n     = 1;
			end else begin
				bytes = {LEAD3 | {4'b0, cu[15:12]}, CONT | {2'b0, cu[11:6]},
					CONT | {2'b0, cu[5:0]}, 8'h0};
				n     = 3;
			end
		end
		// End of string clears everything after the unit is handled.
		if (u.end_of_string) begin
			held_high      = 1'b0;
			held_bits      = '0;
			stream_stopped = 1'b0;
		end
		return n;
	endfunction

	// Put one unit on the input channel, hold it until the transaction is
	// taken, then apply burst pacing. Valid is only lowered when a gap follows.
	task automatic offer_unit(input unit_item_t u, input logic typed, input logic [2:0] n,
		input logic [31:0] bytes);
		code_item  <= u;
		row_typed  <= typed;
		row_n      <= n;
		row_bytes  <= bytes;
		code_valid <= 1'b1;
		@(posedge clk);
		while (!code_ready)
			@(posedge clk);
		@(negedge clk);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			code_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
			// Now and then a long burst, so stretches without idling occur.
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
	endtask

	// Output side stalls on a 16-bit ready mask, reloaded after its last bit with a
	// fresh style: fully open, random, mostly open or mostly stalled.
	always @(negedge clk) begin : receiver
		logic [15:0] stall_mask;
		int          stall_phase;
		if (stall_phase == 0) begin
			case (stall_style_t'($urandom_range(0, 3)))
				READY_ALWAYS: stall_mask = '1;
				READY_RANDOM: stall_mask = 16'($urandom);
				READY_MOSTLY: stall_mask = 16'($urandom) | 16'($urandom);
				default:      stall_mask = 16'($urandom) & 16'($urandom);
			endcase
		end
		utf8_ready  <= stall_mask[stall_phase];
		stall_phase  = (stall_phase + 1) % 16;
	end

	// Scoreboard: predicts on every accepted input transaction and checks
	// every accepted output transaction against the oldest expectation.
	always @(posedge clk) begin : scoreboard
		utf8_item_t  want;
		logic [31:0] bytes;
		int          n;
		if (arst_n) begin
			if (code_valid && code_ready) begin
				if (!stream_stopped)
					live_units++;
				// Model always runs so its state tracks the block, even on
				// rows whose bytes are typed into the table.
				n = encode_unit(code_item, bytes);
				if (row_typed) begin
					n     = int'(row_n);
					bytes = row_bytes;
				end
				for (int i = 0; i < n; i++) begin
					want.out_byte    = bytes[31 - 8 * i -: 8];
					want.last_of_run = (i == n - 1);
					utf8_expected_q.push_back(want);
				end
			end
			if (utf8_valid && utf8_ready) begin
				if (utf8_expected_q.size() == 0) begin
					err_count++;
					$display("%0t: unexpected utf8 transaction, expected none, actual %h/%b",
						$time, utf8_item.out_byte, utf8_item.last_of_run);
				end else begin
					want = utf8_expected_q.pop_front();
					if (utf8_item.out_byte !== want.out_byte) begin
						err_count++;
						$display("%0t: out_byte mismatch, expected %h, actual %h",
							$time, want.out_byte, utf8_item.out_byte);
					end
					if (utf8_item.last_of_run !== want.last_of_run) begin
						err_count++;
						$display("%0t: last_of_run mismatch, expected %b, actual %b",
							$time, want.last_of_run, utf8_item.last_of_run);
					end
				end
			end
		end
	end

	// Watchdog: ends a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("utf16_to_utf8_encoder verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		unit_item_t  u;
		unit_item_t  plan_q [$];
		int unsigned pick;
		int unsigned extra;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r]) begin
			u.code_unit     = directed_rows[r].cu;
			u.end_of_string = directed_rows[r].eos;
			offer_unit(u, directed_rows[r].typed, directed_rows[r].n, directed_rows[r].bytes);
		end

		// Random part: mostly well-formed text with random content (all
		// encoding lengths, surrogate pairs, terminated strings), plus lone
		// and broken surrogates and raw noise. Ignored units do not count.
		while (live_units < DIRECTED_ROWS + RANDOM_UNITS) begin
			pick            = $urandom_range(0, 99);
			u.end_of_string = ($urandom_range(0, 19) == 0);
			if (pick < 22) begin
				u.code_unit = 16'($urandom_range(1, 16'h007F));
				plan_q.push_back(u);
			end else if (pick < 36) begin
				u.code_unit = 16'($urandom_range(16'h0080, 16'h07FF));
				plan_q.push_back(u);
			end else if (pick < 54) begin
				u.code_unit = $urandom_range(0, 1) ? 16'($urandom_range(16'h0800, 16'hD7FF))
					: 16'($urandom_range(16'hE000, 16'hFFFF));
				plan_q.push_back(u);
			end else if (pick < 76) begin
				// surrogate pair; end of string on the high half breaks it
				u.code_unit = 16'($urandom_range(HIGH_SURR_MIN, HIGH_SURR_MAX));
				plan_q.push_back(u);
				u.code_unit     = 16'($urandom_range(LOW_SURR_MIN, LOW_SURR_MAX));
				u.end_of_string = ($urandom_range(0, 19) == 0);
				plan_q.push_back(u);
			end else if (pick < 80) begin
				u.code_unit = 16'($urandom_range(LOW_SURR_MIN, LOW_SURR_MAX));
				plan_q.push_back(u);
			end else if (pick < 86) begin
				// high surrogate followed by anything at all
				u.code_unit     = 16'($urandom_range(HIGH_SURR_MIN, HIGH_SURR_MAX));
				u.end_of_string = 1'b0;
				plan_q.push_back(u);
				u.code_unit = 16'($urandom);
				plan_q.push_back(u);
			end else if (pick < 92) begin
				// terminator, a few ignored units, then the end-of-string mark
				u.code_unit     = '0;
				u.end_of_string = 1'b0;
				plan_q.push_back(u);
				extra = $urandom_range(0, 3);
				repeat (extra) begin
					u.code_unit = 16'($urandom);
					plan_q.push_back(u);
				end
				u.code_unit     = 16'($urandom);
				u.end_of_string = 1'b1;
				plan_q.push_back(u);
			end else begin
				u.code_unit     = 16'($urandom);
				u.end_of_string = 1'($urandom_range(0, 1));
				plan_q.push_back(u);
			end
			while (plan_q.size() != 0) begin
				u = plan_q.pop_front();
				offer_unit(u, PREDICTED, 3'd0, 32'h0);
			end
		end

		code_valid <= 1'b0;
		while (utf8_expected_q.size() != 0)
			@(posedge clk);
		// Let any stray byte surface before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("utf16_to_utf8_encoder verification clean");
		else
			$display("utf16_to_utf8_encoder verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/u16u8_pkg.sv
sv/utf16_to_utf8_encoder.sv
sim/tb_top.sv
